/* design/bdg_pkg.sv */
// Shared types and constants for the big digit glyph emitter.
package bdg_pkg;

  localparam int GLYPH_PITCH = 24;
  localparam int MAX_CHARS   = 11;
  localparam int NUM_DIGITS  = 10;
  localparam int MAG_BITS    = 32;
  localparam int BCD_BITS    = 4 * NUM_DIGITS;

  localparam logic [3:0] MINUS_GLYPH   = 4'd10;
  localparam logic [3:0] DEFAULT_WIDTH = 4'd4;

  localparam logic REG_FIELD_DIGITS   = 1'b0;
  localparam logic REG_PALETTE_SELECT = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_CONV
  } state_t;

  // One converted number, handed from the front end to the glyph sequencer.
  typedef struct packed {
    logic [BCD_BITS-1:0] bcd;
    logic                neg;
    logic [11:0]         bx;
    logic [11:0]         by;
  } job_t;

endpackage

/* design/big_digit_glyph_emitter_core.sv */
// Top level of the big digit glyph emitter: handshake, registers, conversion control.
//
// Renders a signed 32-bit value as a row of decimal glyph words (glyph code
// 0-9, or 10 for a minus sign), left to right, with last set on the final one.
// The text is right-aligned in a field of field_digits characters (0 means 4);
// text longer than the field keeps only its last characters, which can drop
// the sign. pos_x advances 24 pixels per field slot, total_width is the field
// width times 24, and pos_y and palette follow base_y and palette_select.
// Timing: after a word is accepted, the serial shift-and-add-3 converter takes
// one magnitude bit per cycle, its done strobe hands the digits to the glyph
// sequencer, and the sequencer then emits one glyph per cycle while out_ready
// is high. in_ready rises again once the last glyph is loaded into the output
// register. Write configuration only while the block is idle.
module big_digit_glyph_emitter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [3:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] value,
  input  logic [11:0] base_x,
  input  logic [11:0] base_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  glyph,
  output logic [12:0] pos_x,
  output logic [11:0] pos_y,
  output logic        palette,
  output logic [8:0]  total_width,
  output logic        last
);

  bdg_pkg::state_t state;
  bdg_pkg::state_t state_next;

  logic [3:0]  field_digits;
  logic        palette_select;
  logic [3:0]  width;
  logic        neg;
  logic [11:0] bx;
  logic [11:0] by;
  logic [31:0] mag;
  logic        accept;
  logic        conv_done;
  logic        seq_active;
  logic        seq_load;
  logic [bdg_pkg::BCD_BITS-1:0] bcd;
  bdg_pkg::job_t job;

  // Configuration registers; unknown indexes cannot occur with a 1-bit index.
  always_ff @(posedge clk) begin
    if (rst) begin
      field_digits   <= bdg_pkg::DEFAULT_WIDTH;
      palette_select <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bdg_pkg::REG_FIELD_DIGITS:   field_digits   <= cfg_wdata;
        bdg_pkg::REG_PALETTE_SELECT: palette_select <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Zero width falls back to the default field.
  assign width = (field_digits == 4'd0) ? bdg_pkg::DEFAULT_WIDTH : field_digits;

  // Take the magnitude at accept; the most negative value maps to 2^31 exactly.
  assign mag    = value[31] ? (~value + 32'd1) : value;
  assign accept = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      bdg_pkg::ST_IDLE: if (accept)    state_next = bdg_pkg::ST_CONV;
      bdg_pkg::ST_CONV: if (conv_done) state_next = bdg_pkg::ST_IDLE;
      default:          state_next = bdg_pkg::ST_IDLE;
    endcase
  end

  // Control outputs: hold off new words while glyphs are still to be loaded.
  always_comb begin
    in_ready = 1'b0;
    seq_load = 1'b0;
    unique case (state)
      bdg_pkg::ST_IDLE: in_ready = !seq_active;
      bdg_pkg::ST_CONV: seq_load = conv_done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the position and sign for the whole conversion.
  always_ff @(posedge clk) begin
    if (accept) begin
      neg <= value[31];
      bx  <= base_x;
      by  <= base_y;
    end
  end

  bdg_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (bcd)
  );

  assign job.bcd = bcd;
  assign job.neg = neg;
  assign job.bx  = bx;
  assign job.by  = by;

  bdg_glyph_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .load        (seq_load),
    .job         (job),
    .width       (width),
    .palette_sel (palette_select),
    .active      (seq_active),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .glyph       (glyph),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .palette     (palette),
    .total_width (total_width),
    .last        (last)
  );

endmodule

/* design/bdg_dabble.sv */
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
module bdg_dabble (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bdg_pkg::MAG_BITS-1:0]  mag,
  output logic                          done,
  output logic [bdg_pkg::BCD_BITS-1:0]  bcd
);

  logic [bdg_pkg::MAG_BITS-1:0] mag_sr;
  logic [bdg_pkg::BCD_BITS-1:0] bcd_sr;
  logic [bdg_pkg::BCD_BITS-1:0] bcd_adj;
  logic [4:0]                   cnt;
  logic                         busy;

  // Correct every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < bdg_pkg::NUM_DIGITS; i++) begin
      if (bcd_sr[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_sr[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_sr[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'(bdg_pkg::MAG_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_sr <= mag;
      bcd_sr <= '0;
    end else if (busy) begin
      mag_sr <= {mag_sr[bdg_pkg::MAG_BITS-2:0], 1'b0};
      bcd_sr <= {bcd_adj[bdg_pkg::BCD_BITS-2:0], mag_sr[bdg_pkg::MAG_BITS-1]};
    end
  end

  assign bcd = bcd_sr;

endmodule

/* design/bdg_glyph_seq.sv */
// Glyph sequencer: trims or aligns the text and emits one glyph word per step.
module bdg_glyph_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bdg_pkg::job_t     job,
  input  logic [3:0]        width,
  input  logic              palette_sel,
  output logic              active,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        glyph,
  output logic [12:0]       pos_x,
  output logic [11:0]       pos_y,
  output logic              palette,
  output logic [8:0]        total_width,
  output logic              last
);

  logic [bdg_pkg::BCD_BITS-1:0] bcd;
  logic                         neg;
  logic [3:0]                   nd;
  logic [3:0]                   tix;
  logic [3:0]                   rem;
  logic [12:0]                  x;
  logic [11:0]                  by;

  logic [3:0]  ld_nd;
  logic [3:0]  ld_len;
  logic [3:0]  ld_first;
  logic [3:0]  ld_slot;
  logic [3:0]  ld_count;
  logic [12:0] ld_x;
  logic [3:0]  didx;
  logic [3:0]  cur_glyph;
  logic        step;

  // Count significant digits (at least one) and place the text in the field.
  always_comb begin
    ld_nd = 4'd1;
    for (int i = 1; i < bdg_pkg::NUM_DIGITS; i++) begin
      if (job.bcd[4*i +: 4] != 4'd0) begin
        ld_nd = 4'(i + 1);
      end
    end
    ld_len = ld_nd + {3'd0, job.neg};
    if (ld_len > width) begin
      ld_first = ld_len - width;
      ld_slot  = 4'd0;
    end else begin
      ld_first = 4'd0;
      ld_slot  = width - ld_len;
    end
    ld_count = ld_len - ld_first;
    ld_x     = {1'b0, job.bx} + 13'(ld_slot) * 13'(bdg_pkg::GLYPH_PITCH);
  end

  // Pick the character at the current text index.
  always_comb begin
    didx = neg ? (nd - tix) : (nd - 4'd1 - tix);
    case (didx)
      4'd0:    cur_glyph = bcd[3:0];
      4'd1:    cur_glyph = bcd[7:4];
      4'd2:    cur_glyph = bcd[11:8];
      4'd3:    cur_glyph = bcd[15:12];
      4'd4:    cur_glyph = bcd[19:16];
      4'd5:    cur_glyph = bcd[23:20];
      4'd6:    cur_glyph = bcd[27:24];
      4'd7:    cur_glyph = bcd[31:28];
      4'd8:    cur_glyph = bcd[35:32];
      4'd9:    cur_glyph = bcd[39:36];
      default: cur_glyph = 4'd0;
    endcase
    if (neg && tix == 4'd0) begin
      cur_glyph = bdg_pkg::MINUS_GLYPH;
    end
  end

  assign step = active && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        active <= 1'b1;
      end else if (step && rem == 4'd1) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd <= job.bcd;
      neg <= job.neg;
      nd  <= ld_nd;
      tix <= ld_first;
      rem <= ld_count;
      x   <= ld_x;
      by  <= job.by;
    end else if (step) begin
      tix <= tix + 4'd1;
      rem <= rem - 4'd1;
      x   <= x + 13'(bdg_pkg::GLYPH_PITCH);
    end
    if (step) begin
      glyph       <= cur_glyph;
      pos_x       <= x;
      pos_y       <= by;
      palette     <= palette_sel;
      total_width <= 9'(13'(width) * 13'(bdg_pkg::GLYPH_PITCH));
      last        <= (rem == 4'd1);
    end
  end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the big digit glyph emitter core.
`timescale 1ns / 100ps

module testbench;

  // Cycles with no word moving on either side before the run is declared hung.
  // The longest legal quiet stretch is the forced receiver hold-off.
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 17;

  typedef struct packed {
    logic [3:0]  glyph;
    logic [12:0] pos_x;
    logic [11:0] pos_y;
    logic        palette;
    logic [8:0]  total_width;
    logic        last;
  } glyph_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = bdg_pkg::REG_FIELD_DIGITS;
  logic [3:0]  cfg_wdata = 4'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] value = 32'd0;
  logic [11:0] base_x = 12'd0;
  logic [11:0] base_y = 12'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  glyph;
  logic [12:0] pos_x;
  logic [11:0] pos_y;
  logic        palette;
  logic [8:0]  total_width;
  logic        last;

  // Mirror of the block's registers, updated on every write.
  logic [3:0]  field_width_reg = bdg_pkg::DEFAULT_WIDTH;
  logic        palette_reg = 1'b0;

  // Glyph words predicted but not yet seen, oldest first.
  glyph_word_t pending_glyphs[$];

  int fail_count = 0;
  int quiet_cycles = 0;
  int hold_request = 0;
  int hold_left = 0;
  bit steady = 1'b0;

  big_digit_glyph_emitter_core DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .base_x      (base_x),
    .base_y      (base_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .glyph       (glyph),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .palette     (palette),
    .total_width (total_width),
    .last        (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Render one number the way the block should: decimal text with an optional
  // minus, right-aligned in the field, clipped on the left when too long.
  function automatic void predict_glyph_row(logic [31:0] num, logic [11:0] bx,
                                            logic [11:0] by);
    logic [3:0]  text [bdg_pkg::MAX_CHARS];
    logic [3:0]  rev [bdg_pkg::NUM_DIGITS];
    logic [31:0] mag;
    int          nd;
    int          len;
    int          width;
    int          first;
    int          slot;
    int          count;
    glyph_word_t w;
    nd  = 0;
    len = 0;
    // Two's complement negate; the most negative value maps to 2^31 unsigned.
    mag = num[31] ? (~num + 32'd1) : num;
    do begin
      rev[nd] = 4'(mag % 32'd10);
      mag     = mag / 32'd10;
      nd      = nd + 1;
    end while (mag != 32'd0 && nd < bdg_pkg::NUM_DIGITS);
    if (num[31]) begin
      text[len] = bdg_pkg::MINUS_GLYPH;
      len       = len + 1;
    end
    for (int i = 0; i < nd; i++) begin
      text[len] = rev[nd - 1 - i];
      len       = len + 1;
    end
    // A zero width register selects the default width.
    width = (field_width_reg == 4'd0) ? int'(bdg_pkg::DEFAULT_WIDTH)
                                      : int'(field_width_reg);
    if (len > width) begin
      first = len - width;
      slot  = 0;
    end else begin
      first = 0;
      slot  = width - len;
    end
    count = len - first;
    for (int k = 0; k < count; k++) begin
      w.glyph       = text[first + k];
      w.pos_x       = 13'(int'(bx) + (slot + k) * bdg_pkg::GLYPH_PITCH);
      w.pos_y       = by;
      w.palette     = palette_reg;
      w.total_width = 9'(width * bdg_pkg::GLYPH_PITCH);
      w.last        = (k == count - 1);
      pending_glyphs.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Compare the glyph word on the output ports with the oldest prediction.
  task automatic compare_glyph_word();
    glyph_word_t want;
    if (pending_glyphs.size() == 0) begin
      report_mismatch("glyph word with none pending", 32'(glyph), 0);
      return;
    end
    want = pending_glyphs.pop_front();
    if (glyph !== want.glyph) report_mismatch("glyph", 32'(glyph), 32'(want.glyph));
    if (pos_x !== want.pos_x) report_mismatch("pos_x", 32'(pos_x), 32'(want.pos_x));
    if (pos_y !== want.pos_y) report_mismatch("pos_y", 32'(pos_y), 32'(want.pos_y));
    if (palette !== want.palette)
      report_mismatch("palette", 32'(palette), 32'(want.palette));
    if (total_width !== want.total_width)
      report_mismatch("total_width", 32'(total_width), 32'(want.total_width));
    if (last !== want.last) report_mismatch("last", 32'(last), 32'(want.last));
  endtask

  // Receiver: check each accepted word, then choose ready for the next edge.
  // A hold-off request drops ready for a fixed count of cycles.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) compare_glyph_word();
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one number; hold it until accepted, then predict its glyph words.
  task automatic send_number(input logic [31:0] num, input logic [11:0] bx,
                             input logic [11:0] by);
    int gap;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= num;
    base_x   <= bx;
    base_y   <= by;
    do @(posedge clk); while (!in_ready);
    predict_glyph_row(num, bx, by);
  endtask

  // Drop valid and wait until every predicted glyph word has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_glyphs.size() != 0) @(posedge clk);
  endtask

  // Write both registers; call only while the block is idle. Drive random
  // upper bits on the palette write, which the block must ignore.
  task automatic set_config(input logic [3:0] digits, input logic pal);
    cfg_we    <= 1'b1;
    cfg_addr  <= bdg_pkg::REG_FIELD_DIGITS;
    cfg_wdata <= digits;
    @(posedge clk);
    field_width_reg = digits;
    cfg_addr  <= bdg_pkg::REG_PALETTE_SELECT;
    cfg_wdata <= {3'($urandom), pal};
    @(posedge clk);
    palette_reg = pal;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mix of full-range values, small values, extreme values, and powers of ten and
  // their neighbors, which change the digit count.
  function automatic logic [31:0] pick_number();
    logic [31:0] p;
    p = 32'd1;
    case ($urandom_range(5))
      0: p = 32'($urandom_range(0, 99));
      1: begin
        repeat ($urandom_range(1, 9)) p = p * 32'd10;
        p = p - 32'($urandom_range(0, 1));
      end
      2: begin
        case ($urandom_range(3))
          0: p = 32'h8000_0000;
          1: p = 32'h7fff_ffff;
          2: p = 32'h0000_0000;
          default: p = 32'hffff_ffff;
        endcase
      end
      default: p = $urandom;
    endcase
    if ($urandom_range(1) == 1) p = -p;
    return p;
  endfunction

  // Reset values: width 4, palette 0. Covers truncation and the most
  // negative value at the far corner of the screen.
  task automatic test_reset_defaults();
    send_number(32'd0, 12'd0, 12'd0);
    send_number(32'hffff_ffff, 12'd100, 12'd200);
    send_number(32'd12345, 12'd7, 12'd9);
    send_number(32'h8000_0000, 12'hfff, 12'hfff);
    wait_drained();
  endtask

  // Width extremes and exact fits; one-wide field drops the sign.
  task automatic test_field_widths();
    set_config(4'd0, 1'b1);
    send_number(-32'd123, 12'd50, 12'd60);
    send_number(32'd7, 12'hfff, 12'd0);
    wait_drained();
    set_config(4'd1, 1'b0);
    send_number(-32'd5, 12'd1, 12'd2);
    send_number(32'h7fff_ffff, 12'd0, 12'hfff);
    wait_drained();
    set_config(4'd15, 1'b1);
    send_number(32'h8000_0000, 12'hfff, 12'hfff);
    send_number(32'h7fff_ffff, 12'd0, 12'd0);
    send_number(32'd0, 12'hfff, 12'd3);
    wait_drained();
    set_config(4'd11, 1'b1);
    send_number(32'h8000_0000, 12'd10, 12'd20);
    send_number(32'd1_000_000_000, 12'd30, 12'd40);
    send_number(-32'd999_999_999, 12'd55, 12'd66);
    wait_drained();
    set_config(4'd2, 1'b0);
    send_number(32'd9, 12'd5, 12'd5);
    send_number(32'd10, 12'd5, 12'd5);
    send_number(-32'd10, 12'd5, 12'd5);
    wait_drained();
  endtask

  // Random numbers and positions under several random settings.
  task automatic test_random_numbers();
    for (int ph = 0; ph < 4; ph++) begin
      set_config(4'($urandom_range(0, 15)), 1'($urandom));
      repeat (18) send_number(pick_number(), 12'($urandom), 12'($urandom));
      wait_drained();
    end
  endtask

  // Hold the receiver off while numbers keep coming, so the block fills
  // and stalls its input.
  task automatic test_output_backpressure();
    set_config(4'd15, 1'b1);
    steady       = 1'b1;
    hold_request = HOLD_CYCLES;
    repeat (8) send_number(pick_number(), 12'($urandom), 12'($urandom));
    steady = 1'b0;
    wait_drained();
  endtask

  // Long stretch with no idling on either side.
  task automatic test_back_to_back();
    set_config(4'd11, 1'b0);
    steady = 1'b1;
    repeat (15) send_number(pick_number(), 12'($urandom), 12'($urandom));
    wait_drained();
    steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_field_widths();
    test_random_numbers();
    test_output_backpressure();
    test_back_to_back();
    // Let any stray glyph word surface before the verdict.
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
